// ===== src/pixel_histogram_accumulator_core_defines.svh =====
// Assertion macros shared by the histogram core.
`ifndef PIXEL_HISTOGRAM_ACCUMULATOR_CORE_DEFINES_SVH
`define PIXEL_HISTOGRAM_ACCUMULATOR_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is low.
`define PHIST_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is low.
`define PHIST_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/phist_pkg.sv =====
`default_nettype none

package phist_pkg;

    // Field widths of the words on the channels
    localparam int BIN_ADDR_W  = 10;
    localparam int OUT_COUNT_W = 32;
    localparam int CFG_DATA_W  = 4;
    localparam int CFG_INDEX_W = 2;

    // Actions carried in an input word
    localparam logic [1:0] ACT_COUNT = 2'd0;
    localparam logic [1:0] ACT_READ  = 2'd1;
    localparam logic [1:0] ACT_CLEAR = 2'd2;

    // Histogram modes
    localparam logic [1:0] MODE_LUMA     = 2'd0;
    localparam logic [1:0] MODE_LUMA_SAT = 2'd1;
    localparam logic [1:0] MODE_RGB      = 2'd2;

    // Register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_BINS_LOG2 = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_HIST_MODE = 2'd1;

    localparam logic [3:0] BINS_LOG2_RESET = 4'd8;

    // Luma weights, scaled by 1024
    localparam logic [17:0] LUMA_R = 18'd306;
    localparam logic [17:0] LUMA_G = 18'd601;
    localparam logic [17:0] LUMA_B = 18'd117;

    typedef struct packed {
        logic [1:0]            action;
        logic [7:0]            red;
        logic [7:0]            green;
        logic [7:0]            blue;
        logic [BIN_ADDR_W-1:0] bin_address;
    } t_in_word;

    typedef struct packed {
        logic [OUT_COUNT_W-1:0] bin_count;
        logic [OUT_COUNT_W-1:0] pixel_count;
    } t_out_word;

    // Bins one counted pixel touches
    typedef struct packed {
        logic                             valid;
        logic [1:0]                       last;
        logic [2:0][BIN_ADDR_W-1:0]       addr;
    } t_bump_plan;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_RD,
        S_WR,
        S_RES
    } t_state;

endpackage

`default_nettype wire

// ===== src/phist_ram.sv =====
`default_nettype none

module phist_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 768
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read, held while no read is issued
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

// ===== src/phist_bin_map.sv =====
`default_nettype none

module phist_bin_map
    import phist_pkg::*;
#(
    parameter int MAX_BINS_PER_CHANNEL = 256
) (
    input  wire logic [7:0] i_red,
    input  wire logic [7:0] i_green,
    input  wire logic [7:0] i_blue,
    input  wire logic [3:0] i_bins_log2,
    input  wire logic [1:0] i_mode,
    output t_bump_plan      o_plan
);

    // Largest bins_log2 the store can hold
    localparam int TOP_LOG2 = $clog2(MAX_BINS_PER_CHANNEL + 1) - 1;

    logic [3:0]            w_lg;
    logic [3:0]            w_sh_wide;
    logic [2:0]            w_sh;
    logic [BIN_ADDR_W-1:0] w_bins;
    logic [17:0]           w_luma_sum;
    logic [7:0]            w_luma;
    logic [7:0]            w_d1;
    logic [7:0]            w_d2;
    logic [7:0]            w_sat;

    // Clamp the bin count to what the store supports
    always_comb begin
        if (i_bins_log2 < 4'd1) begin
            w_lg = 4'd1;
        end else if (i_bins_log2 > 4'(TOP_LOG2)) begin
            w_lg = 4'(TOP_LOG2);
        end else begin
            w_lg = i_bins_log2;
        end
    end

    assign w_sh_wide = 4'd8 - w_lg;
    assign w_sh      = w_sh_wide[2:0];
    assign w_bins    = BIN_ADDR_W'(1) << w_lg;

    // Luma and saturation
    assign w_luma_sum = LUMA_R * {10'd0, i_red} + LUMA_G * {10'd0, i_green}
                      + LUMA_B * {10'd0, i_blue};
    assign w_luma     = w_luma_sum[17:10];
    assign w_d1       = (i_red > i_green) ? (i_red - i_green) : (i_green - i_red);
    assign w_d2       = (i_green > i_blue) ? (i_green - i_blue) : (i_blue - i_green);
    assign w_sat      = (w_d1 > w_d2) ? w_d1 : w_d2;

    // Build the list of bins to bump
    always_comb begin
        o_plan = '0;
        case (i_mode)
            MODE_LUMA: begin
                o_plan.valid   = 1'b1;
                o_plan.last    = 2'd0;
                o_plan.addr[0] = BIN_ADDR_W'(w_luma >> w_sh);
            end
            MODE_LUMA_SAT: begin
                o_plan.valid   = 1'b1;
                o_plan.last    = 2'd1;
                o_plan.addr[0] = BIN_ADDR_W'(w_luma >> w_sh);
                o_plan.addr[1] = w_bins + BIN_ADDR_W'(w_sat >> w_sh);
            end
            MODE_RGB: begin
                o_plan.valid   = 1'b1;
                o_plan.last    = 2'd2;
                o_plan.addr[0] = BIN_ADDR_W'(i_red >> w_sh);
                o_plan.addr[1] = w_bins + BIN_ADDR_W'(i_green >> w_sh);
                o_plan.addr[2] = (w_bins << 1) + BIN_ADDR_W'(i_blue >> w_sh);
            end
            default: begin
                o_plan.valid = 1'b0;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== src/pixel_histogram_accumulator_core.sv =====
// Pixel histogram accumulator.
// Input channel (i_valid/o_ready, i_data) takes one word: count a pixel, read a
// bin, or clear the store and the pixel counter. Only a read gives an output
// word (o_valid/i_ready, o_data) holding the bin count and pixels counted.
// Bins live in one RAM of 3 * MAX_BINS_PER_CHANNEL entries; each bump is a
// read cycle followed by a write-back cycle. A counted pixel bumps one, two or
// three bins by mode; a read does one RAM read and then waits in S_RES until
// the output register frees; a clear sweeps every entry. o_ready stays low
// until the word in hand is done, so only one word is worked on at a time.
// Reset (synchronous, i_rst_n low) sets bins_log2 to 8 and mode to luma, then
// sweeps all 3 * MAX_BINS_PER_CHANNEL RAM entries to zero with o_ready low.
// Configuration writes are taken at any time through i_cfg_we.
// The output register holds its word until taken; the next input word is
// accepted meanwhile, and a following read waits until the register frees.
`default_nettype none

`include "pixel_histogram_accumulator_core_defines.svh"

module pixel_histogram_accumulator_core
    import phist_pkg::*;
#(
    parameter int MAX_BINS_PER_CHANNEL = 256,
    parameter int COUNT_WIDTH          = 32
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_valid,
    output logic                        o_ready,
    input  wire t_in_word               i_data,
    output logic                        o_valid,
    input  wire logic                   i_ready,
    output t_out_word                   o_data,
    input  wire logic                   i_cfg_we,
    input  wire logic [CFG_INDEX_W-1:0] i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  i_cfg_wdata
);

    localparam int DEPTH  = 3 * MAX_BINS_PER_CHANNEL;
    localparam int ADDR_W = $clog2(DEPTH);

    t_state                  r_state, n_state;
    logic [3:0]              r_bins_log2;
    logic [1:0]              r_mode;
    logic [COUNT_WIDTH-1:0]  r_pix_cnt;
    logic [ADDR_W-1:0]       r_clr_addr;
    t_bump_plan              r_plan;
    logic [1:0]              r_idx;
    logic                    r_is_read;
    logic                    r_hit;
    logic                    r_out_valid;
    t_out_word               r_out;

    t_bump_plan              w_plan;
    logic                    w_accept;
    logic                    w_out_free;
    logic                    w_ram_we;
    logic [ADDR_W-1:0]       w_ram_waddr;
    logic [COUNT_WIDTH-1:0]  w_ram_wdata;
    logic                    w_ram_re;
    logic [ADDR_W-1:0]       w_cur_addr;
    logic [COUNT_WIDTH-1:0]  w_ram_rdata;
    logic [COUNT_WIDTH-1:0]  w_bin_inc;
    logic [COUNT_WIDTH-1:0]  w_pix_inc;
    logic [COUNT_WIDTH-1:0]  w_bin_val;

    // Clamp a count to the 32-bit output field
    function automatic logic [OUT_COUNT_W-1:0] to_out(input logic [COUNT_WIDTH-1:0] v);
        logic [OUT_COUNT_W-1:0] res;
        if (v > COUNT_WIDTH'({OUT_COUNT_W{1'b1}})) begin
            res = '1;
        end else begin
            res = OUT_COUNT_W'(v);
        end
        return res;
    endfunction

    phist_bin_map #(
        .MAX_BINS_PER_CHANNEL(MAX_BINS_PER_CHANNEL)
    ) u_bin_map (
        .i_red      (i_data.red),
        .i_green    (i_data.green),
        .i_blue     (i_data.blue),
        .i_bins_log2(r_bins_log2),
        .i_mode     (r_mode),
        .o_plan     (w_plan)
    );

    phist_ram #(
        .WIDTH(COUNT_WIDTH),
        .DEPTH(DEPTH)
    ) u_bin_ram (
        .i_clk  (i_clk),
        .i_we   (w_ram_we),
        .i_waddr(w_ram_waddr),
        .i_wdata(w_ram_wdata),
        .i_re   (w_ram_re),
        .i_raddr(w_cur_addr),
        .o_rdata(w_ram_rdata)
    );

    assign o_ready    = (r_state == S_IDLE);
    assign w_accept   = i_valid && o_ready;
    assign w_out_free = !r_out_valid || i_ready;
    assign w_cur_addr = r_plan.addr[r_idx][ADDR_W-1:0];
    assign w_bin_inc  = (w_ram_rdata == '1) ? w_ram_rdata : w_ram_rdata + 1'b1;
    assign w_pix_inc  = (r_pix_cnt == '1) ? r_pix_cnt : r_pix_cnt + 1'b1;
    assign w_bin_val  = r_hit ? w_ram_rdata : '0;

    // Next state and RAM controls
    always_comb begin
        n_state     = r_state;
        w_ram_we    = 1'b0;
        w_ram_waddr = w_cur_addr;
        w_ram_wdata = w_bin_inc;
        w_ram_re    = 1'b0;
        case (r_state)
            S_CLEAR: begin
                w_ram_we    = 1'b1;
                w_ram_waddr = r_clr_addr;
                w_ram_wdata = '0;
                if (r_clr_addr == ADDR_W'(DEPTH - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (w_accept) begin
                    case (i_data.action)
                        ACT_COUNT: n_state = w_plan.valid ? S_RD : S_IDLE;
                        ACT_READ:  n_state = S_RD;
                        ACT_CLEAR: n_state = S_CLEAR;
                        default:   n_state = S_IDLE;
                    endcase
                end
            end
            S_RD: begin
                w_ram_re = 1'b1;
                n_state  = r_is_read ? S_RES : S_WR;
            end
            S_WR: begin
                w_ram_we = 1'b1;
                n_state  = (r_idx == r_plan.last) ? S_IDLE : S_RD;
            end
            S_RES: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bins_log2 <= BINS_LOG2_RESET;
            r_mode      <= MODE_LUMA;
        end else if (i_cfg_we) begin
            if (i_cfg_index == REG_BINS_LOG2) begin
                r_bins_log2 <= i_cfg_wdata;
            end else if (i_cfg_index == REG_HIST_MODE) begin
                r_mode <= i_cfg_wdata[1:0];
            end
        end
    end

    // Sequencer registers: sweep address, bump index, read flag, pixel counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr <= '0;
            r_pix_cnt  <= '0;
            r_idx      <= '0;
            r_is_read  <= 1'b0;
        end else begin
            case (r_state)
                S_CLEAR: begin
                    r_clr_addr <= r_clr_addr + 1'b1;
                end
                S_IDLE: begin
                    if (w_accept) begin
                        r_idx <= '0;
                        if (i_data.action == ACT_CLEAR) begin
                            r_clr_addr <= '0;
                            r_pix_cnt  <= '0;
                        end
                        r_is_read <= (i_data.action == ACT_READ);
                    end
                end
                S_WR: begin
                    if (r_idx == r_plan.last) begin
                        r_pix_cnt <= w_pix_inc;
                    end else begin
                        r_idx <= r_idx + 1'b1;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // Latch the bins to bump, or the bin to read
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            if (i_data.action == ACT_READ) begin
                r_plan.valid   <= 1'b1;
                r_plan.last    <= 2'd0;
                r_plan.addr[0] <= i_data.bin_address;
                r_plan.addr[1] <= '0;
                r_plan.addr[2] <= '0;
                r_hit          <= (i_data.bin_address < BIN_ADDR_W'(DEPTH));
            end else begin
                r_plan <= w_plan;
                r_hit  <= 1'b1;
            end
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == S_RES && w_out_free) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_RES && w_out_free) begin
            r_out.bin_count   <= to_out(w_bin_val);
            r_out.pixel_count <= to_out(r_pix_cnt);
        end
    end

    assign o_valid = r_out_valid;
    assign o_data  = r_out;

    // Checks
    `PHIST_ASSERT_SAME(a_no_accept_in_clear, i_clk, i_rst_n, r_state == S_CLEAR, !o_ready, "word accepted during clear sweep")
    `PHIST_ASSERT_NEXT(a_clear_starts, i_clk, i_rst_n, w_accept && i_data.action == ACT_CLEAR, r_state == S_CLEAR && r_pix_cnt == '0, "clear action did not start sweep")
    `PHIST_ASSERT_SAME(a_write_when_owned, i_clk, i_rst_n, w_ram_we, r_state == S_CLEAR || r_state == S_WR, "bin RAM written outside sweep or write-back")
    `PHIST_ASSERT_SAME(a_no_rw_overlap, i_clk, i_rst_n, w_ram_re, !w_ram_we, "bin RAM read and written in one cycle")

endmodule

`default_nettype wire
